[design/atte_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package atte_pkg;
  localparam int PARAM_SLOTS = 8;
  localparam int SLOT_W = $clog2(PARAM_SLOTS);
  localparam int CNT_W = $clog2(PARAM_SLOTS + 1);

  localparam logic [31:0] FG_DEFAULT = 32'hffaaaaaa;
  localparam logic [31:0] BG_DEFAULT = 32'hff000000;

  localparam logic [1:0] CMD_DRAW   = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_CLRLN  = 2'd2;
  localparam logic [1:0] CMD_SCROLL = 2'd3;

  localparam logic [0:0] REG_COLS = 1'b0;
  localparam logic [0:0] REG_ROWS = 1'b1;

  typedef enum logic [1:0] {
    PM_NORMAL = 2'd0,
    PM_ESC    = 2'd1,
    PM_CSI    = 2'd2
  } pmode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SGR,
    ST_EMIT1,
    ST_EMIT2
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  cell_column;
    logic [5:0]  cell_row;
    logic [7:0]  glyph_code;
    logic [31:0] fore_color;
    logic [31:0] back_color;
    logic        last;
  } result_t;

  function automatic logic [31:0] palette(input logic bright, input logic [2:0] idx);
    logic [31:0] c;
    case ({bright, idx})
      4'd0:  c = 32'hff000000;
      4'd1:  c = 32'hffaa0000;
      4'd2:  c = 32'hff00aa00;
      4'd3:  c = 32'hffaa5500;
      4'd4:  c = 32'hff0000aa;
      4'd5:  c = 32'hffaa00aa;
      4'd6:  c = 32'hff00aaaa;
      4'd7:  c = 32'hffaaaaaa;
      4'd8:  c = 32'hff555555;
      4'd9:  c = 32'hffff5555;
      4'd10: c = 32'hff55ff55;
      4'd11: c = 32'hffffff55;
      4'd12: c = 32'hff5555ff;
      4'd13: c = 32'hffff55ff;
      4'd14: c = 32'hff55ffff;
      default: c = 32'hffffffff;
    endcase
    return c;
  endfunction

  // 0 acts as 1, above 64 acts as 64; returns dim-1
  function automatic logic [5:0] dim_max(input logic [6:0] v);
    logic [5:0] m;
    if (v == 7'd0) m = 6'd0;
    else if (v > 7'd64) m = 6'd63;
    else m = 6'(v - 7'd1);
    return m;
  endfunction
endpackage
`default_nettype wire

[design/atte_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface atte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface atte_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [5:0]  cell_column;
  logic [5:0]  cell_row;
  logic [7:0]  glyph_code;
  logic [31:0] fore_color;
  logic [31:0] back_color;
  logic        last;
  modport source (output valid, output command, output cell_column, output cell_row,
                  output glyph_code, output fore_color, output back_color, output last,
                  input ready);
  modport sink (input valid, input command, input cell_column, input cell_row,
                input glyph_code, input fore_color, input back_color, input last,
                output ready);
endinterface
`default_nettype wire

[design/ansi_text_terminal_engine_top.sv]
// ANSI text terminal command engine.
// in_if carries one console byte per request (valid/ready). out_if carries
// drawing commands: draw cell, clear screen, clear line, scroll one row;
// last marks the final command caused by a byte (zero, one or two).
// cfg_we/cfg_index/cfg_wdata write text_columns (0) and text_rows (1);
// write only while idle. A write clamps the cursor into the new size.
// A byte is taken in IDLE and decoded in DECODE. An SGR final byte then
// walks the stored parameters one per cycle through a single
// compare/palette unit. Each result is held in an output register until
// ready is high; the block returns to IDLE after the last result is taken.
// A stalled receiver simply holds the output register; no input is taken.
// Reset (synchronous, rst_n low): 30 columns, 20 rows, normal parse mode,
// parameters cleared, cursor home, colors light gray on black.
`timescale 1ns / 1ps
`default_nettype none
module ansi_text_terminal_engine_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  atte_in_if.sink         in_if,
  atte_out_if.source      out_if,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [6:0] cfg_wdata
);
  atte_pkg::state_t st_r, st_nxt;
  atte_pkg::pmode_t pm_r, pm_nxt;
  logic [6:0]  cols_r, cols_nxt, rows_r, rows_nxt;
  logic [31:0] vals_r [atte_pkg::PARAM_SLOTS];
  logic [31:0] vals_nxt [atte_pkg::PARAM_SLOTS];
  logic [atte_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic        seen_r, seen_nxt;
  logic [5:0]  ccol_r, ccol_nxt, crow_r, crow_nxt;
  logic [31:0] fg_r, fg_nxt, bg_r, bg_nxt;
  logic [7:0]  ch_r, ch_nxt;
  logic [atte_pkg::SLOT_W:0] idx_r, idx_nxt;
  atte_pkg::result_t res1_r, res1_nxt, res2_r, res2_nxt;
  logic        has2_r, has2_nxt;

  logic [5:0] cmax, rmax;
  logic [31:0] sv;
  logic [32:0] sum;
  logic [3:0] dg;
  logic [atte_pkg::SLOT_W-1:0] ks;
  logic [6:0] ncol;
  logic       nscroll;
  atte_pkg::result_t rz;

  assign cmax = atte_pkg::dim_max(cols_r);
  assign rmax = atte_pkg::dim_max(rows_r);
  assign sv = vals_r[idx_r[atte_pkg::SLOT_W-1:0]];

  function automatic logic [5:0] sv_h(input logic [31:0] v, input logic given,
                                      input logic [5:0] mx);
    logic [31:0] d;
    d = (given && v != 32'd0) ? v - 32'd1 : 32'd0;
    return (d < 32'(mx)) ? d[5:0] : mx;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= atte_pkg::ST_IDLE;
      pm_r <= atte_pkg::PM_NORMAL;
      cols_r <= 7'd30;
      rows_r <= 7'd20;
      for (int i = 0; i < atte_pkg::PARAM_SLOTS; i++) vals_r[i] <= '0;
      cnt_r <= '0;
      seen_r <= 1'b0;
      ccol_r <= '0;
      crow_r <= '0;
      fg_r <= atte_pkg::FG_DEFAULT;
      bg_r <= atte_pkg::BG_DEFAULT;
      has2_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      pm_r <= pm_nxt;
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
      for (int i = 0; i < atte_pkg::PARAM_SLOTS; i++) vals_r[i] <= vals_nxt[i];
      cnt_r <= cnt_nxt;
      seen_r <= seen_nxt;
      ccol_r <= ccol_nxt;
      crow_r <= crow_nxt;
      fg_r <= fg_nxt;
      bg_r <= bg_nxt;
      has2_r <= has2_nxt;
    end
    ch_r <= ch_nxt;
    idx_r <= idx_nxt;
    res1_r <= res1_nxt;
    res2_r <= res2_nxt;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      atte_pkg::ST_IDLE: if (in_if.valid) st_nxt = atte_pkg::ST_DECODE;
      atte_pkg::ST_DECODE: begin
        if (pm_r == atte_pkg::PM_CSI && ch_r == "m" && (seen_r || cnt_r != '0))
          st_nxt = atte_pkg::ST_SGR;
        else if (pm_r == atte_pkg::PM_ESC || pm_r == atte_pkg::PM_CSI)
          st_nxt = (ch_r == "J" || ch_r == "K") && pm_r == atte_pkg::PM_CSI &&
                   !(ch_r == "J" && (seen_r || cnt_r != '0) && vals_r[0] != 32'd0 &&
                     vals_r[0] != 32'd2) && !(ch_r >= "0" && ch_r <= "9") ?
                   atte_pkg::ST_EMIT1 : atte_pkg::ST_IDLE;
        else if (ch_r == 8'h0a || ch_r == 8'h08 || ch_r == 8'h7f ||
                 (ch_r >= 8'h20 && ch_r != 8'h7f) || (ch_r == 8'h1b && 1'b0))
          st_nxt = (ch_r == 8'h0a && !(crow_r >= rmax)) ? atte_pkg::ST_IDLE
                   : atte_pkg::ST_EMIT1;
        else st_nxt = atte_pkg::ST_IDLE;
      end
      atte_pkg::ST_SGR:
        if (idx_r + 1'b1 >= (atte_pkg::SLOT_W+1)'(cnt_r)) st_nxt = atte_pkg::ST_IDLE;
      atte_pkg::ST_EMIT1:
        if (out_if.ready) st_nxt = has2_r ? atte_pkg::ST_EMIT2 : atte_pkg::ST_IDLE;
      atte_pkg::ST_EMIT2: if (out_if.ready) st_nxt = atte_pkg::ST_IDLE;
      default: st_nxt = atte_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    pm_nxt = pm_r;
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    for (int i = 0; i < atte_pkg::PARAM_SLOTS; i++) vals_nxt[i] = vals_r[i];
    cnt_nxt = cnt_r;
    seen_nxt = seen_r;
    ccol_nxt = ccol_r;
    crow_nxt = crow_r;
    fg_nxt = fg_r;
    bg_nxt = bg_r;
    ch_nxt = ch_r;
    idx_nxt = idx_r;
    res1_nxt = res1_r;
    res2_nxt = res2_r;
    has2_nxt = has2_r;
    rz = '0;
    sum = '0;
    dg = ch_r[3:0];
    ks = (cnt_r >= atte_pkg::CNT_W'(atte_pkg::PARAM_SLOTS - 1)) ?
         atte_pkg::SLOT_W'(atte_pkg::PARAM_SLOTS - 1) : cnt_r[atte_pkg::SLOT_W-1:0];
    ncol = {1'b0, ccol_r} + 7'd1;
    nscroll = 1'b0;
    case (st_r)
      atte_pkg::ST_IDLE: begin
        ch_nxt = in_if.char_code;
        if (cfg_we) begin
          if (cfg_index == atte_pkg::REG_COLS) begin
            cols_nxt = cfg_wdata;
            if (ccol_r > atte_pkg::dim_max(cfg_wdata))
              ccol_nxt = atte_pkg::dim_max(cfg_wdata);
          end else begin
            rows_nxt = cfg_wdata;
            if (crow_r > atte_pkg::dim_max(cfg_wdata))
              crow_nxt = atte_pkg::dim_max(cfg_wdata);
          end
        end
      end
      atte_pkg::ST_DECODE: begin
        has2_nxt = 1'b0;
        idx_nxt = '0;
        rz.back_color = bg_r;
        rz.last = 1'b1;
        if (pm_r == atte_pkg::PM_ESC) begin
          pm_nxt = (ch_r == "[") ? atte_pkg::PM_CSI : atte_pkg::PM_NORMAL;
          cnt_nxt = '0;
          seen_nxt = 1'b0;
          for (int i = 0; i < atte_pkg::PARAM_SLOTS; i++) vals_nxt[i] = '0;
        end else if (pm_r == atte_pkg::PM_CSI) begin
          if (ch_r >= "0" && ch_r <= "9") begin
            vals_nxt[ks] = (vals_r[ks] << 3) + (vals_r[ks] << 1) + 32'(dg);
            seen_nxt = 1'b1;
          end else if (ch_r == ";") begin
            if (cnt_r < atte_pkg::CNT_W'(atte_pkg::PARAM_SLOTS)) cnt_nxt = cnt_r + 1'b1;
            seen_nxt = 1'b0;
          end else begin
            pm_nxt = atte_pkg::PM_NORMAL;
            if ((seen_r || cnt_r != '0) && cnt_r < atte_pkg::CNT_W'(atte_pkg::PARAM_SLOTS))
              cnt_nxt = cnt_r + 1'b1;
            // cnt_r is the old count: a parameter is given once the new count covers it
            case (ch_r)
              "A": begin
                if (seen_r || cnt_r != '0) begin
                  if (vals_r[0] > 32'(crow_r)) crow_nxt = '0;
                  else crow_nxt = crow_r - vals_r[0][5:0];
                end else if (crow_r != '0) crow_nxt = crow_r - 6'd1;
              end
              "B", "C": begin
                sum = {1'b0, (seen_r || cnt_r != '0) ? vals_r[0] : 32'd1} +
                      33'((ch_r == "B") ? crow_r : ccol_r);
                if (ch_r == "B")
                  crow_nxt = (sum[31:0] < 32'(rmax)) ? sum[5:0] : rmax;
                else
                  ccol_nxt = (sum[31:0] < 32'(cmax)) ? sum[5:0] : cmax;
              end
              "D": begin
                if (seen_r || cnt_r != '0) begin
                  if (vals_r[0] > 32'(ccol_r)) ccol_nxt = '0;
                  else ccol_nxt = ccol_r - vals_r[0][5:0];
                end else if (ccol_r != '0) ccol_nxt = ccol_r - 6'd1;
              end
              "H", "f": begin
                crow_nxt = sv_h(vals_r[0], seen_r || cnt_r != '0, rmax);
                ccol_nxt = sv_h(vals_r[1], cnt_r != '0, cmax);
              end
              "J": begin
                if (!(seen_r || cnt_r != '0) || vals_r[0] == 32'd0 || vals_r[0] == 32'd2) begin
                  ccol_nxt = '0;
                  crow_nxt = '0;
                  rz.command = atte_pkg::CMD_CLEAR;
                  res1_nxt = rz;
                end
              end
              "K": begin
                rz.command = atte_pkg::CMD_CLRLN;
                rz.cell_column = ccol_r;
                rz.cell_row = crow_r;
                res1_nxt = rz;
              end
              "m": begin
                if (!(seen_r || cnt_r != '0)) begin
                  fg_nxt = atte_pkg::FG_DEFAULT;
                  bg_nxt = atte_pkg::BG_DEFAULT;
                end
              end
              default: ;
            endcase
          end
        end else begin
          pm_nxt = atte_pkg::PM_NORMAL;
          if (ch_r == 8'h1b) pm_nxt = atte_pkg::PM_ESC;
          else if (ch_r == 8'h0d) ccol_nxt = '0;
          else if (ch_r == 8'h0a) begin
            ccol_nxt = '0;
            if (crow_r >= rmax) begin
              crow_nxt = rmax;
              rz.command = atte_pkg::CMD_SCROLL;
              res1_nxt = rz;
            end else crow_nxt = crow_r + 6'd1;
          end else if (ch_r == 8'h08 || ch_r == 8'h7f) begin
            ccol_nxt = (ccol_r != '0) ? ccol_r - 6'd1 : '0;
            rz.command = atte_pkg::CMD_DRAW;
            rz.cell_column = ccol_nxt;
            rz.cell_row = crow_r;
            rz.glyph_code = 8'h20;
            rz.fore_color = fg_r;
            res1_nxt = rz;
          end else if (ch_r == 8'h09) begin
            ncol = {1'b0, ccol_r[5:3], 3'b000} + 7'd8;
            ccol_nxt = (ncol > {1'b0, cmax}) ? cmax : ncol[5:0];
          end else if (ch_r >= 8'h20) begin
            rz.command = atte_pkg::CMD_DRAW;
            rz.cell_column = ccol_r;
            rz.cell_row = crow_r;
            rz.glyph_code = ch_r;
            rz.fore_color = fg_r;
            if (ncol > {1'b0, cmax}) begin
              ccol_nxt = '0;
              if (crow_r >= rmax) begin
                crow_nxt = rmax;
                nscroll = 1'b1;
              end else crow_nxt = crow_r + 6'd1;
            end else ccol_nxt = ncol[5:0];
            rz.last = !nscroll;
            res1_nxt = rz;
            has2_nxt = nscroll;
            res2_nxt = '0;
            res2_nxt.command = atte_pkg::CMD_SCROLL;
            res2_nxt.back_color = bg_r;
            res2_nxt.last = 1'b1;
          end
        end
      end
      atte_pkg::ST_SGR: begin
        // one parameter per cycle through the shared range check
        idx_nxt = idx_r + 1'b1;
        if (sv == 32'd0) begin
          fg_nxt = atte_pkg::FG_DEFAULT;
          bg_nxt = atte_pkg::BG_DEFAULT;
        end else if (sv >= 32'd30 && sv <= 32'd37)
          fg_nxt = atte_pkg::palette(1'b0, 3'(sv - 32'd30));
        else if (sv >= 32'd40 && sv <= 32'd47)
          bg_nxt = atte_pkg::palette(1'b0, 3'(sv - 32'd40));
        else if (sv >= 32'd90 && sv <= 32'd97)
          fg_nxt = atte_pkg::palette(1'b1, 3'(sv - 32'd90));
        else if (sv >= 32'd100 && sv <= 32'd107)
          bg_nxt = atte_pkg::palette(1'b1, 3'(sv - 32'd100));
      end
      default: ;
    endcase
  end

  assign in_if.ready = (st_r == atte_pkg::ST_IDLE);
  assign out_if.valid = (st_r == atte_pkg::ST_EMIT1) || (st_r == atte_pkg::ST_EMIT2);
  atte_pkg::result_t ro;
  assign ro = (st_r == atte_pkg::ST_EMIT2) ? res2_r : res1_r;
  assign out_if.command = ro.command;
  assign out_if.cell_column = ro.cell_column;
  assign out_if.cell_row = ro.cell_row;
  assign out_if.glyph_code = ro.glyph_code;
  assign out_if.fore_color = ro.fore_color;
  assign out_if.back_color = ro.back_color;
  assign out_if.last = ro.last;
endmodule
`default_nettype wire
